// ===== rtl/per_app_flow_stats_flush_defines.svh =====
// Assertion macros for the per-application flow statistics block
`ifndef PER_APP_FLOW_STATS_FLUSH_DEFINES_SVH
`define PER_APP_FLOW_STATS_FLUSH_DEFINES_SVH
// Check that a condition implies a consequence in the next cycle
`define PAFS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence in the same cycle
`define PAFS_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
`endif

// ===== rtl/pafs_pkg.sv =====
// Shared types and constants for the per-application flow statistics block
package pafs_pkg;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_LIMIT   = 2'd2;
    localparam logic [47:0] BYTE_LIMIT_RST   = 48'd100000000;
    localparam logic [39:0] PACKET_LIMIT_RST = 40'd100000;
    localparam logic [31:0] FLOW_LIMIT_RST   = 32'd1000;

    typedef enum logic [0:0] {
        MODE_ADD   = 1'b0,
        MODE_DRAIN = 1'b1
    } mode_t;

    typedef enum logic [0:0] {
        CLR_BUSY = 1'b0,
        CLR_DONE = 1'b1
    } clr_state_t;

    // back part sequence: wait, read the entry, check limits
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ,
        PH_CALC
    } phase_t;

    // one table entry
    typedef struct packed {
        logic [31:0] flows;
        logic [39:0] dl_pk;
        logic [39:0] ul_pk;
        logic [47:0] dl_by;
        logic [47:0] ul_by;
        logic [62:0] tm;
    } entry_t;

    // classified command from the front to the back part
    typedef struct packed {
        mode_t       mode;
        logic [9:0]  app_id;
        logic [31:0] dl_packets;
        logic [31:0] ul_packets;
        logic [39:0] dl_bytes;
        logic [39:0] ul_bytes;
        logic [62:0] session_time;
    } cmd_t;

    typedef struct packed {
        logic [9:0]  report_app;
        logic [31:0] flow_count;
        logic [39:0] down_packets;
        logic [39:0] up_packets;
        logic [47:0] down_bytes;
        logic [47:0] up_bytes;
        logic [62:0] report_time;
        logic        from_drain;
    } report_t;
endpackage

// ===== rtl/pafs_if.sv =====
// Valid/ready channel interfaces for commands and reports
interface pafs_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [9:0]  app_id;
    logic [31:0] dl_packets;
    logic [31:0] ul_packets;
    logic [39:0] dl_bytes;
    logic [39:0] ul_bytes;
    logic [62:0] session_time;
    modport source (output valid, mode, app_id, dl_packets, ul_packets, dl_bytes,
                    ul_bytes, session_time, input ready);
    modport sink (input valid, mode, app_id, dl_packets, ul_packets, dl_bytes,
                  ul_bytes, session_time, output ready);
endinterface

interface pafs_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  report_app;
    logic [31:0] flow_count;
    logic [39:0] down_packets;
    logic [39:0] up_packets;
    logic [47:0] down_bytes;
    logic [47:0] up_bytes;
    logic [62:0] report_time;
    logic        from_drain;
    modport source (output valid, report_app, flow_count, down_packets, up_packets,
                    down_bytes, up_bytes, report_time, from_drain, input ready);
    modport sink (input valid, report_app, flow_count, down_packets, up_packets,
                  down_bytes, up_bytes, report_time, from_drain, output ready);
endinterface

// ===== rtl/pafs_front.sv =====
// Front part: accept items, drop out-of-range ids, queue commands
module pafs_front import pafs_pkg::*; #(
    parameter int unsigned APP_COUNT = 1024
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    pafs_in_if.sink in_ch,
    output logic  cmd_valid,
    input  logic  cmd_pop,
    output cmd_t  cmd
);
    localparam int unsigned DEPTH = 2;
    cmd_t       q_reg [DEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       push;
    logic       keep;

    assign in_ch.ready = en && (cnt_reg != 2'(DEPTH));
    assign push = in_ch.valid && in_ch.ready;
    // ids not below the table size cause nothing
    assign keep = ({22'd0, in_ch.app_id} < 32'(APP_COUNT));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[rd_reg];

    // advance queue pointers
    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        if (push && keep)
        begin
            wr_next = ~wr_reg;
        end
        if (cmd_pop)
        begin
            rd_next = ~rd_reg;
        end
        cnt_next = cnt_reg + 2'(push && keep) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    // store the payload
    always_ff @(posedge clk)
    begin
        if (push && keep)
        begin
            q_reg[wr_reg] <= '{mode: mode_t'(in_ch.mode), app_id: in_ch.app_id,
                dl_packets: in_ch.dl_packets, ul_packets: in_ch.ul_packets,
                dl_bytes: in_ch.dl_bytes, ul_bytes: in_ch.ul_bytes,
                session_time: in_ch.session_time};
        end
    end
endmodule

// ===== rtl/pafs_back.sv =====
// Back part: read-modify-write of the table, limit checks, report register
module pafs_back import pafs_pkg::*; #(
    parameter int unsigned APP_COUNT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [47:0] byte_limit,
    input  logic [39:0] packet_limit,
    input  logic [31:0] flow_limit,
    input  logic        cmd_valid,
    output logic        cmd_pop,
    input  cmd_t        cmd,
    output logic        clr_done,
    pafs_out_if.source  out_ch
);
    localparam int unsigned AW = (APP_COUNT > 1) ? $clog2(APP_COUNT) : 1;

    entry_t     mem [APP_COUNT];
    entry_t     rdata_reg;
    entry_t     wdata_reg;
    logic       we_reg;
    logic [AW-1:0] waddr_reg;
    clr_state_t clr_reg, clr_next;
    logic [AW:0] clr_cnt_reg, clr_cnt_next;
    phase_t     ph_reg, ph_next;
    cmd_t       c_reg;
    entry_t     upd_reg;
    logic [48:0] bsum;
    logic [40:0] psum;
    logic       over;
    report_t    rep_reg;
    logic       rep_v_reg;
    logic [40:0] s_dp, s_up;
    logic [48:0] s_db, s_ub;
    logic [32:0] s_fl;
    entry_t     upd_next;

    assign clr_done = (clr_reg == CLR_DONE);
    assign cmd_pop = clr_done && cmd_valid && (ph_reg == PH_IDLE) && !rep_v_reg;

    // saturating adds on the read entry
    always_comb
    begin
        s_dp = {1'b0, rdata_reg.dl_pk} + {9'd0, c_reg.dl_packets};
        s_up = {1'b0, rdata_reg.ul_pk} + {9'd0, c_reg.ul_packets};
        s_db = {1'b0, rdata_reg.dl_by} + {9'd0, c_reg.dl_bytes};
        s_ub = {1'b0, rdata_reg.ul_by} + {9'd0, c_reg.ul_bytes};
        s_fl = {1'b0, rdata_reg.flows} + 33'd1;
        upd_next.dl_pk = s_dp[40] ? '1 : s_dp[39:0];
        upd_next.ul_pk = s_up[40] ? '1 : s_up[39:0];
        upd_next.dl_by = s_db[48] ? '1 : s_db[47:0];
        upd_next.ul_by = s_ub[48] ? '1 : s_ub[47:0];
        upd_next.flows = s_fl[32] ? '1 : s_fl[31:0];
        upd_next.tm    = c_reg.session_time;
    end

    // limit compare on the registered update
    assign bsum = {1'b0, upd_reg.dl_by} + {1'b0, upd_reg.ul_by};
    assign psum = {1'b0, upd_reg.dl_pk} + {1'b0, upd_reg.ul_pk};
    assign over = (bsum > {1'b0, byte_limit}) || (psum > {1'b0, packet_limit})
                  || (upd_reg.flows > flow_limit);

    // phase sequence
    always_comb
    begin
        case (ph_reg)
            PH_IDLE: ph_next = cmd_pop ? PH_READ : PH_IDLE;
            PH_READ: ph_next = (c_reg.mode == MODE_ADD) ? PH_CALC : PH_IDLE;
            PH_CALC: ph_next = PH_IDLE;
            default: ph_next = PH_IDLE;
        endcase
    end

    // clearing sweep after reset
    always_comb
    begin
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        case (clr_reg)
            CLR_BUSY:
            begin
                clr_cnt_next = clr_cnt_reg + (AW+1)'(1);
                if (clr_cnt_reg == (AW+1)'(APP_COUNT - 1))
                begin
                    clr_next = CLR_DONE;
                end
            end
            CLR_DONE: clr_next = CLR_DONE;
            default:  clr_next = CLR_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= CLR_BUSY;
            clr_cnt_reg <= '0;
            ph_reg      <= PH_IDLE;
            rep_v_reg   <= 1'b0;
            we_reg      <= 1'b0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
            ph_reg      <= ph_next;
            we_reg      <= 1'b0;
            if (out_ch.valid && out_ch.ready)
            begin
                rep_v_reg <= 1'b0;
            end
            if (ph_reg == PH_READ && c_reg.mode == MODE_DRAIN)
            begin
                we_reg    <= 1'b1;
                rep_v_reg <= (rdata_reg.flows != 32'd0);
            end
            if (ph_reg == PH_READ && c_reg.mode == MODE_ADD)
            begin
                we_reg <= 1'b1;
            end
            if (ph_reg == PH_CALC && over)
            begin
                we_reg    <= 1'b1;
                rep_v_reg <= 1'b1;
            end
        end
    end

    // payload registers and table write data
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            c_reg <= cmd;
        end
        if (ph_reg == PH_READ)
        begin
            upd_reg   <= upd_next;
            waddr_reg <= AW'(c_reg.app_id);
            if (c_reg.mode == MODE_DRAIN)
            begin
                wdata_reg <= '0;
                rep_reg <= '{report_app: c_reg.app_id, flow_count: rdata_reg.flows,
                    down_packets: rdata_reg.dl_pk, up_packets: rdata_reg.ul_pk,
                    down_bytes: rdata_reg.dl_by, up_bytes: rdata_reg.ul_by,
                    report_time: rdata_reg.tm, from_drain: 1'b1};
            end
            else
            begin
                wdata_reg <= upd_next;
            end
        end
        if (ph_reg == PH_CALC && over)
        begin
            wdata_reg <= '{flows: '0, dl_pk: '0, ul_pk: '0, dl_by: '0, ul_by: '0,
                           tm: upd_reg.tm};
            rep_reg <= '{report_app: c_reg.app_id, flow_count: upd_reg.flows,
                down_packets: upd_reg.dl_pk, up_packets: upd_reg.ul_pk,
                down_bytes: upd_reg.dl_by, up_bytes: upd_reg.ul_by,
                report_time: upd_reg.tm, from_drain: 1'b0};
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (!clr_done)
        begin
            mem[clr_cnt_reg[AW-1:0]] <= '0;
        end
        else if (we_reg)
        begin
            mem[waddr_reg] <= wdata_reg;
        end
        rdata_reg <= mem[AW'(cmd.app_id)];
    end

    assign out_ch.valid        = rep_v_reg;
    assign out_ch.report_app   = rep_reg.report_app;
    assign out_ch.flow_count   = rep_reg.flow_count;
    assign out_ch.down_packets = rep_reg.down_packets;
    assign out_ch.up_packets   = rep_reg.up_packets;
    assign out_ch.down_bytes   = rep_reg.down_bytes;
    assign out_ch.up_bytes     = rep_reg.up_bytes;
    assign out_ch.report_time  = rep_reg.report_time;
    assign out_ch.from_drain   = rep_reg.from_drain;
endmodule

// ===== rtl/per_app_flow_stats_flush.sv =====
// Top level of the per-application flow statistics block
//   channel   dir   payload
//   in_ch     in    mode, app_id, session counts, session_time
//   out_ch    out   report_app, totals, report_time, from_drain
//   cfg       in    byte_limit, packet_limit, flow_limit
// In the back part a drain reads the entry and writes it back cleared; a session reads
// the entry, updates it and checks the limits, writes it back, and clears it when it reports.
// The back part takes one item at a time. The front queue holds two.
// After reset a clearing sweep zeroes every table entry; no item is accepted then.
// A pending report stalls the back part until taken; the queue accepts until full.
`include "per_app_flow_stats_flush_defines.svh"
module per_app_flow_stats_flush import pafs_pkg::*; #(
    parameter int unsigned APP_COUNT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pafs_in_if.sink               in_ch,
    pafs_out_if.source            out_ch
);
    logic [47:0] byte_limit_reg;
    logic [39:0] packet_limit_reg;
    logic [31:0] flow_limit_reg;
    logic        cmd_valid;
    logic        cmd_pop;
    cmd_t        cmd;
    logic        clr_done;

    // write limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_limit_reg   <= BYTE_LIMIT_RST;
            packet_limit_reg <= PACKET_LIMIT_RST;
            flow_limit_reg   <= FLOW_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BYTE_LIMIT:   byte_limit_reg   <= cfg_data;
                CFG_PACKET_LIMIT: packet_limit_reg <= cfg_data[39:0];
                CFG_FLOW_LIMIT:   flow_limit_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    pafs_front #(.APP_COUNT(APP_COUNT)) u_front (
        .clk(clk), .rst_n(rst_n), .en(clr_done), .in_ch(in_ch),
        .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
    );

    pafs_back #(.APP_COUNT(APP_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n), .byte_limit(byte_limit_reg),
        .packet_limit(packet_limit_reg), .flow_limit(flow_limit_reg),
        .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd),
        .clr_done(clr_done), .out_ch(out_ch)
    );

    `PAFS_ASSERT_NOW(a_no_accept_clr, clk, rst_n, !clr_done, !in_ch.ready, "accept during clear")
    `PAFS_ASSERT_NOW(a_pop_valid, clk, rst_n, cmd_pop, cmd_valid, "pop from empty queue")
    `PAFS_ASSERT_NEXT(a_no_pop_rep, clk, rst_n, out_ch.valid && !out_ch.ready, !cmd_pop, "pop while report held")
endmodule

// ===== tb/sv/per_app_flow_stats_flush_tb.sv =====
// Self-checking testbench for the per-application flow statistics block
module per_app_flow_stats_flush_tb;
    import pafs_pkg::*;

    localparam int unsigned APPS      = 1024;
    localparam longint      MAX_CYCLE = 2000000;
    localparam int          SETTLE    = 24;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pafs_in_if  in_ch ();
    pafs_out_if out_ch ();

    per_app_flow_stats_flush #(.APP_COUNT(APPS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // shadow of the statistics table and limits
    logic [31:0] flows_tab [APPS];
    logic [39:0] dl_pk_tab [APPS];
    logic [39:0] ul_pk_tab [APPS];
    logic [47:0] dl_by_tab [APPS];
    logic [47:0] ul_by_tab [APPS];
    logic [62:0] tm_tab    [APPS];
    logic [47:0] byte_lim;
    logic [39:0] packet_lim;
    logic [31:0] flow_lim;

    cmd_t    session_q [$];
    report_t report_q  [$];
    cmd_t    cur_cmd;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      errors;
    int      n_items;
    int      n_limit_reports;
    int      n_drain_reports;
    longint  cycles;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input int w);
        logic [63:0] top;
        logic [63:0] s;
        top = (64'd1 << w) - 64'd1;
        s = a + b;
        return (s > top) ? top : s;
    endfunction

    function automatic report_t snap_entry(input logic [9:0] idx, input logic drain);
        report_t r;
        r.report_app   = idx;
        r.flow_count   = flows_tab[idx];
        r.down_packets = dl_pk_tab[idx];
        r.up_packets   = ul_pk_tab[idx];
        r.down_bytes   = dl_by_tab[idx];
        r.up_bytes     = ul_by_tab[idx];
        r.report_time  = tm_tab[idx];
        r.from_drain   = drain;
        return r;
    endfunction

    // apply one session or drain to the shadow table; returns 1 when a report is due
    function automatic bit apply_cmd(input cmd_t c, output report_t r);
        logic [9:0] i;
        bit         hit;
        i = c.app_id;
        hit = 1'b0;
        r = '0;
        if (c.mode == MODE_DRAIN) begin
            if (flows_tab[i] != 32'd0) begin
                r = snap_entry(i, 1'b1);
                hit = 1'b1;
            end
            tm_tab[i] = '0;
        end
        else begin
            dl_pk_tab[i] = 40'(sat_add(64'(dl_pk_tab[i]), 64'(c.dl_packets), 40));
            ul_pk_tab[i] = 40'(sat_add(64'(ul_pk_tab[i]), 64'(c.ul_packets), 40));
            dl_by_tab[i] = 48'(sat_add(64'(dl_by_tab[i]), 64'(c.dl_bytes), 48));
            ul_by_tab[i] = 48'(sat_add(64'(ul_by_tab[i]), 64'(c.ul_bytes), 48));
            tm_tab[i]    = c.session_time;
            flows_tab[i] = 32'(sat_add(64'(flows_tab[i]), 64'd1, 32));
            if ({16'd0, dl_by_tab[i]} + {16'd0, ul_by_tab[i]} > {16'd0, byte_lim}
                || {24'd0, dl_pk_tab[i]} + {24'd0, ul_pk_tab[i]} > {24'd0, packet_lim}
                || flows_tab[i] > flow_lim) begin
                r = snap_entry(i, 1'b0);
                hit = 1'b1;
            end
            else begin
                return 1'b0;
            end
        end
        // clear counters; time survives a limit report
        flows_tab[i] = '0;
        dl_pk_tab[i] = '0;
        ul_pk_tab[i] = '0;
        dl_by_tab[i] = '0;
        ul_by_tab[i] = '0;
        return hit;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // drive pending items; predict on acceptance
    always @(posedge clk) begin
        report_t r;
        cycles <= cycles + 1;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                n_items++;
                if (apply_cmd(cur_cmd, r)) begin
                    report_q.push_back(r);
                end
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (session_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_cmd = session_q.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.mode         <= cur_cmd.mode;
                    in_ch.app_id       <= cur_cmd.app_id;
                    in_ch.dl_packets   <= cur_cmd.dl_packets;
                    in_ch.ul_packets   <= cur_cmd.ul_packets;
                    in_ch.dl_bytes     <= cur_cmd.dl_bytes;
                    in_ch.ul_bytes     <= cur_cmd.ul_bytes;
                    in_ch.session_time <= cur_cmd.session_time;
                end
                else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // take reports and compare against the oldest expectation
    always @(posedge clk) begin
        report_t e;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected report: expected none, got app %0d",
                             $time, out_ch.report_app);
                    errors++;
                end
                else begin
                    e = report_q.pop_front();
                    if (e.from_drain) n_drain_reports++;
                    else n_limit_reports++;
                    check_field("report_app", 64'(e.report_app), 64'(out_ch.report_app));
                    check_field("flow_count", 64'(e.flow_count), 64'(out_ch.flow_count));
                    check_field("down_packets", 64'(e.down_packets),
                                64'(out_ch.down_packets));
                    check_field("up_packets", 64'(e.up_packets), 64'(out_ch.up_packets));
                    check_field("down_bytes", 64'(e.down_bytes), 64'(out_ch.down_bytes));
                    check_field("up_bytes", 64'(e.up_bytes), 64'(out_ch.up_bytes));
                    check_field("report_time", 64'(e.report_time),
                                64'(out_ch.report_time));
                    check_field("from_drain", 64'(e.from_drain), 64'(out_ch.from_drain));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (cycles > MAX_CYCLE) begin
            $display("%0t: timeout with %0d reports outstanding", $time, report_q.size());
            $display("per_app_flow_stats_flush_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly small counts, sometimes full width, all ones or zero
    function automatic logic [63:0] rand_count(input int w, input int small_max);
        int k;
        k = $urandom_range(99);
        if (k < 60) return 64'($urandom_range(small_max));
        if (k < 85) return rand64() & ((64'd1 << w) - 64'd1);
        if (k < 93) return (64'd1 << w) - 64'd1;
        return 64'd0;
    endfunction

    function automatic cmd_t make_cmd(input logic drain, input logic [9:0] app,
                                      input int small_max);
        cmd_t c;
        c.mode         = drain ? MODE_DRAIN : MODE_ADD;
        c.app_id       = app;
        c.dl_packets   = 32'(rand_count(32, small_max));
        c.ul_packets   = 32'(rand_count(32, small_max));
        c.dl_bytes     = 40'(rand_count(40, small_max * 100));
        c.ul_bytes     = 40'(rand_count(40, small_max * 100));
        c.session_time = 63'(rand64());
        return c;
    endfunction

    function automatic cmd_t fixed_cmd(input mode_t m, input logic [9:0] app,
                                       input logic [63:0] pk, input logic [63:0] by,
                                       input logic [62:0] tm);
        cmd_t c;
        c.mode         = m;
        c.app_id       = app;
        c.dl_packets   = 32'(pk);
        c.ul_packets   = 32'(pk);
        c.dl_bytes     = 40'(by);
        c.ul_bytes     = 40'(by);
        c.session_time = tm;
        return c;
    endfunction

    // hold until every item is taken and every report has arrived, then settle
    task automatic wait_quiet();
        while (session_q.size() != 0 || in_ch.valid || report_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_BYTE_LIMIT:   byte_lim   = val;
            CFG_PACKET_LIMIT: packet_lim = val[39:0];
            CFG_FLOW_LIMIT:   flow_lim   = val[31:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(input logic [47:0] by, input logic [39:0] pk,
                              input logic [31:0] fl);
        write_reg(CFG_BYTE_LIMIT, by);
        write_reg(CFG_PACKET_LIMIT, {8'd0, pk});
        write_reg(CFG_FLOW_LIMIT, {16'd0, fl});
    endtask

    // random sessions and drains on a few hot entries plus scattered ones
    task automatic random_burst(input int count, input int small_max);
        logic [9:0] app;
        int         k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            if (k < 70) app = 10'($urandom_range(7));
            else if (k < 80) app = 10'h3FF;
            else app = 10'($urandom_range(APPS - 1));
            session_q.push_back(make_cmd($urandom_range(99) < 15, app, small_max));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.app_id = '0;
        in_ch.dl_packets = '0;
        in_ch.ul_packets = '0;
        in_ch.dl_bytes = '0;
        in_ch.ul_bytes = '0;
        in_ch.session_time = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        n_items = 0;
        n_limit_reports = 0;
        n_drain_reports = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        byte_lim = BYTE_LIMIT_RST;
        packet_lim = PACKET_LIMIT_RST;
        flow_lim = FLOW_LIMIT_RST;
        for (int i = 0; i < APPS; i++) begin
            flows_tab[i] = '0;
            dl_pk_tab[i] = '0;
            ul_pk_tab[i] = '0;
            dl_by_tab[i] = '0;
            ul_by_tab[i] = '0;
            tm_tab[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset limits, extremes, idle drain, report then drain
        session_q.push_back(fixed_cmd(MODE_ADD, 10'd0, 64'd0, 64'd0, 63'd0));
        session_q.push_back(fixed_cmd(MODE_ADD, 10'h3FF, 64'hFFFF_FFFF,
                                      64'hFF_FFFF_FFFF, {63{1'b1}}));
        session_q.push_back(fixed_cmd(MODE_DRAIN, 10'd0, 64'd0, 64'd0, 63'd0));
        session_q.push_back(fixed_cmd(MODE_DRAIN, 10'd0, 64'd0, 64'd0, 63'd0));
        session_q.push_back(fixed_cmd(MODE_DRAIN, 10'h3FF, 64'd0, 64'd0, 63'd0));
        session_q.push_back(fixed_cmd(MODE_ADD, 10'd2, 64'd50000, 64'd10, 63'd77));
        session_q.push_back(fixed_cmd(MODE_ADD, 10'd2, 64'd1, 64'd10, 63'd78));
        session_q.push_back(fixed_cmd(MODE_ADD, 10'd3, 64'd1, 64'd50000000, 63'd5));
        session_q.push_back(fixed_cmd(MODE_ADD, 10'd3, 64'd1, 64'd1, 63'd6));
        session_q.push_back(fixed_cmd(MODE_DRAIN, 10'd3, 64'd0, 64'd0, 63'd0));
        session_q.push_back(fixed_cmd(MODE_DRAIN, 10'd2, 64'd0, 64'd0, 63'd0));
        session_q.push_back(fixed_cmd(MODE_DRAIN, 10'd517, 64'd0, 64'd0, 63'd0));
        wait_quiet();

        // small limits, no idling
        set_limits(48'd5000, 40'd50, 32'd4);
        random_burst(100, 20);
        wait_quiet();

        // zero limits: every session reports; sender idles
        send_idle_pct = 73;
        set_limits(48'd0, 40'd0, 32'd0);
        random_burst(100, 20);
        wait_quiet();

        // all-ones limits: push one entry into saturation, then drain it
        send_idle_pct = 0;
        recv_stall_pct = 73;
        set_limits({48{1'b1}}, {40{1'b1}}, {32{1'b1}});
        for (int n = 0; n < 260; n++) begin
            session_q.push_back(fixed_cmd(MODE_ADD, 10'd9, 64'hFFFF_FFFF,
                                          64'hFF_FFFF_FFFF, 63'(rand64())));
            session_q[$].ul_packets = '0;
            session_q[$].ul_bytes = '0;
        end
        session_q.push_back(fixed_cmd(MODE_DRAIN, 10'd9, 64'd0, 64'd0, 63'd0));
        random_burst(60, 20);
        for (int a = 0; a < 8; a++) begin
            session_q.push_back(fixed_cmd(MODE_DRAIN, 10'(a), 64'd0, 64'd0, 63'd0));
        end
        wait_quiet();

        // random mid limits; both sides idle
        send_idle_pct = 13;
        recv_stall_pct = 13;
        set_limits(48'($urandom_range(20000, 1000)), 40'($urandom_range(200, 10)),
                   32'($urandom_range(6, 1)));
        random_burst(100, 30);
        wait_quiet();

        $display("Covered %0d items: %0d limit reports, %0d drain reports.",
                 n_items, n_limit_reports, n_drain_reports);
        $display("Limits swept from zero to all ones under four idle profiles.");
        if (errors == 0) begin
            $display("per_app_flow_stats_flush_tb: PASS");
        end
        else begin
            $display("per_app_flow_stats_flush_tb: FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/pafs_pkg.sv
rtl/pafs_if.sv
rtl/pafs_front.sv
rtl/pafs_back.sv
rtl/per_app_flow_stats_flush.sv
tb/sv/per_app_flow_stats_flush_tb.sv
